[hw/rtl/ddo_pkg.sv]
// Shared types, widths and constants of the differential-drive odometry block.
package ddo_pkg;

  localparam int DIST_W     = 24;
  localparam int INV_W      = 24;
  localparam int RATE_W     = 12;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 200;

  localparam int POS_W  = 32;
  localparam int HEAD_W = 31;
  localparam int QUAT_W = 18;
  localparam int VEL_W  = 32;

  localparam int CORDIC_STEPS = 24;
  localparam int WRAP_STEPS   = 14;
  localparam int IDX_W        = 5;

  localparam int SUM_W  = 26;
  localparam int DT_W   = 42;
  localparam int ANG_W  = 44;
  localparam int MA_W   = 34;
  localparam int MB_W   = 26;
  localparam int PROD_W = 60;
  localparam int XY_W   = 34;
  localparam int Z_W    = 32;
  localparam int ACC_W  = 56;

  localparam logic [CFG_IDX_W-1:0] REG_INV_TRACK   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_RATE = 1'b1;

  localparam logic [INV_W-1:0]  INV_TRACK_RESET = 24'd313569;
  localparam logic [RATE_W-1:0] RATE_RESET      = 12'd120;

  localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
  localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
  localparam logic signed [31:0] TWO_PI_Q28  = 32'sd1686629713;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_DT,
    OP_DT,
    OP_WRAP_MID,
    OP_WRAP_HEAD,
    OP_WRAP_STEP,
    OP_COR_MID,
    OP_COR_HALF,
    OP_COR_STEP,
    OP_MUL_DSC,
    OP_POSX,
    OP_MUL_DSS,
    OP_POSY,
    OP_HEAD,
    OP_QUAT,
    OP_MUL_LIN,
    OP_LIN,
    OP_MUL_ALO,
    OP_ALO,
    OP_MUL_AHI,
    OP_AHI,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  // atan(2^-i), Q.28
  function automatic logic signed [Z_W-1:0] atan_q28(input logic [IDX_W-1:0] i);
    logic signed [Z_W-1:0] r;
    unique case (i)
      5'd0:  r = 32'sd210828714;
      5'd1:  r = 32'sd124459457;
      5'd2:  r = 32'sd65760959;
      5'd3:  r = 32'sd33381290;
      5'd4:  r = 32'sd16755422;
      5'd5:  r = 32'sd8385879;
      5'd6:  r = 32'sd4193963;
      5'd7:  r = 32'sd2097109;
      5'd8:  r = 32'sd1048571;
      5'd9:  r = 32'sd524287;
      5'd10: r = 32'sd262144;
      5'd11: r = 32'sd131072;
      5'd12: r = 32'sd65536;
      5'd13: r = 32'sd32768;
      5'd14: r = 32'sd16384;
      5'd15: r = 32'sd8192;
      5'd16: r = 32'sd4096;
      5'd17: r = 32'sd2048;
      5'd18: r = 32'sd1024;
      5'd19: r = 32'sd512;
      5'd20: r = 32'sd256;
      5'd21: r = 32'sd128;
      5'd22: r = 32'sd64;
      5'd23: r = 32'sd32;
      5'd24: r = 32'sd16;
      5'd25: r = 32'sd8;
      5'd26: r = 32'sd4;
      5'd27: r = 32'sd2;
      5'd28: r = 32'sd1;
      5'd29: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/ddo_datapath.sv]
// Odometry datapath: shared multiplier, angle wrap unit, CORDIC, pose and result registers.
module ddo_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ddo_pkg::dp_cmd_t                    cmd_i,
  input  logic [ddo_pkg::IN_DATA_W-1:0]       in_data_i,
  input  logic                                cfg_we_i,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ddo_pkg::CFG_W-1:0]           cfg_data_i,
  output logic [ddo_pkg::OUT_DATA_W-1:0]      out_data_o
);

  localparam int WK_W = $clog2(ddo_pkg::WRAP_STEPS);

  logic [ddo_pkg::INV_W-1:0]  inv_q;
  logic [ddo_pkg::RATE_W-1:0] rate_q;

  logic signed [ddo_pkg::DIST_W-1:0] left_w, right_w;
  logic signed [ddo_pkg::SUM_W-1:0]  diff_q, ds_q;
  logic signed [ddo_pkg::DT_W-1:0]   dt_q;
  logic signed [ddo_pkg::PROD_W-1:0] prod_q;
  logic signed [ddo_pkg::MA_W-1:0]   ma;
  logic signed [ddo_pkg::MB_W-1:0]   mb;

  logic signed [ddo_pkg::POS_W-1:0]  pose_x_q, pose_y_q;
  logic signed [ddo_pkg::HEAD_W-1:0] heading_q;

  logic                         sign_q;
  logic [ddo_pkg::ANG_W-1:0]    mag_q;
  logic signed [ddo_pkg::ANG_W-1:0] wrap_in;
  logic [ddo_pkg::ANG_W:0]      mod_sh;
  logic [WK_W-1:0]              wk;
  logic signed [31:0]           r0, r1;
  logic signed [ddo_pkg::HEAD_W-1:0] wrap_res;

  logic signed [ddo_pkg::XY_W-1:0] x_q, y_q, cos_v, sin_v;
  logic signed [ddo_pkg::Z_W-1:0]  z_q, ang32, atan_v;
  logic                            neg_q;

  logic signed [ddo_pkg::QUAT_W-1:0] qz_q, qw_q;
  logic signed [ddo_pkg::VEL_W-1:0]  lin_q, ang_v;
  logic signed [ddo_pkg::ACC_W-1:0]  acc_q, p56, acc_rnd;
  logic signed [ddo_pkg::PROD_W-1:0] rnd_dt, rnd_pos, rnd_lin;
  logic signed [ddo_pkg::XY_W-1:0]   rnd_qz, rnd_qw;

  function automatic logic signed [31:0] sat32(input logic signed [59:0] v);
    if (v > 60'sd2147483647) return 32'sh7fffffff;
    if (v < -60'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [17:0] clamp_unit(input logic signed [33:0] v);
    if (v > 34'sd65536) return 18'sd65536;
    if (v < -34'sd65536) return -18'sd65536;
    return v[17:0];
  endfunction

  assign left_w  = in_data_i[23:0];
  assign right_w = in_data_i[47:24];

  // operand select for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      ddo_pkg::OP_MUL_DT: begin
        ma = {10'b0, inv_q};
        mb = diff_q;
      end
      ddo_pkg::OP_MUL_DSC: begin
        ma = cos_v;
        mb = ds_q;
      end
      ddo_pkg::OP_MUL_DSS: begin
        ma = sin_v;
        mb = ds_q;
      end
      ddo_pkg::OP_MUL_LIN: begin
        ma = {22'b0, rate_q};
        mb = ds_q;
      end
      ddo_pkg::OP_MUL_ALO: begin
        ma = {13'b0, dt_q[20:0]};
        mb = {14'b0, rate_q};
      end
      ddo_pkg::OP_MUL_AHI: begin
        ma = {{13{dt_q[41]}}, dt_q[41:21]};
        mb = {14'b0, rate_q};
      end
      default: ;
    endcase
  end

  // wrap unit: truncating remainder by 2*pi, then fold into [-pi, pi]
  always_comb begin
    if (cmd_i.op == ddo_pkg::OP_WRAP_HEAD) wrap_in = 44'(heading_q) + 44'(dt_q);
    else wrap_in = 44'(heading_q) + 44'(dt_q >>> 1);
    wk     = WK_W'(ddo_pkg::WRAP_STEPS - 1) - cmd_i.idx[WK_W-1:0];
    mod_sh = {14'b0, ddo_pkg::TWO_PI_Q28[30:0]} << wk;
    r0     = {1'b0, mag_q[30:0]};
    if (sign_q) r0 = -r0;
    if (r0 > ddo_pkg::PI_Q28) r1 = r0 - ddo_pkg::TWO_PI_Q28;
    else if (r0 < -ddo_pkg::PI_Q28) r1 = r0 + ddo_pkg::TWO_PI_Q28;
    else r1 = r0;
    wrap_res = r1[30:0];
  end

  always_comb begin
    if (cmd_i.op == ddo_pkg::OP_COR_HALF) ang32 = 32'(heading_q >>> 1);
    else ang32 = 32'(wrap_res);
    atan_v = ddo_pkg::atan_q28(cmd_i.idx);
    cos_v  = neg_q ? -x_q : x_q;
    sin_v  = neg_q ? -y_q : y_q;
  end

  assign p56     = prod_q[55:0];
  assign rnd_dt  = (prod_q + 60'sd128) >>> 8;
  assign rnd_pos = (prod_q + (60'sd1 <<< 34)) >>> 35;
  assign rnd_lin = (prod_q + 60'sd16) >>> 5;
  assign rnd_qz  = (sin_v + 34'sd8192) >>> 14;
  assign rnd_qw  = (cos_v + 34'sd8192) >>> 14;
  assign acc_rnd = (acc_q + 56'sd2048) >>> 12;
  assign ang_v   = sat32(60'(acc_rnd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q     <= ddo_pkg::INV_TRACK_RESET;
      rate_q    <= ddo_pkg::RATE_RESET;
      pose_x_q  <= '0;
      pose_y_q  <= '0;
      heading_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ddo_pkg::REG_INV_TRACK:   inv_q  <= cfg_data_i;
          ddo_pkg::REG_UPDATE_RATE: rate_q <= cfg_data_i[ddo_pkg::RATE_W-1:0];
        endcase
      end
      case (cmd_i.op)
        ddo_pkg::OP_POSX: pose_x_q  <= sat32(60'(pose_x_q) + rnd_pos);
        ddo_pkg::OP_POSY: pose_y_q  <= sat32(60'(pose_y_q) + rnd_pos);
        ddo_pkg::OP_HEAD: heading_q <= wrap_res;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    case (cmd_i.op)
      ddo_pkg::OP_LOAD: begin
        diff_q <= 26'(right_w) - 26'(left_w);
        ds_q   <= 26'(right_w) + 26'(left_w);
      end
      ddo_pkg::OP_DT: dt_q <= rnd_dt[ddo_pkg::DT_W-1:0];
      ddo_pkg::OP_WRAP_MID, ddo_pkg::OP_WRAP_HEAD: begin
        sign_q <= wrap_in[ddo_pkg::ANG_W-1];
        mag_q  <= wrap_in[ddo_pkg::ANG_W-1] ? 44'(-wrap_in) : 44'(wrap_in);
      end
      ddo_pkg::OP_WRAP_STEP: begin
        if ({1'b0, mag_q} >= mod_sh) mag_q <= mag_q - mod_sh[ddo_pkg::ANG_W-1:0];
      end
      ddo_pkg::OP_COR_MID, ddo_pkg::OP_COR_HALF: begin
        x_q <= ddo_pkg::CORDIC_GAIN_Q30;
        y_q <= '0;
        if (ang32 > ddo_pkg::HALF_PI_Q28) begin
          z_q   <= ang32 - ddo_pkg::PI_Q28;
          neg_q <= 1'b1;
        end else if (ang32 < -ddo_pkg::HALF_PI_Q28) begin
          z_q   <= ang32 + ddo_pkg::PI_Q28;
          neg_q <= 1'b1;
        end else begin
          z_q   <= ang32;
          neg_q <= 1'b0;
        end
      end
      ddo_pkg::OP_COR_STEP: begin
        if (z_q >= 0) begin
          x_q <= x_q - (y_q >>> cmd_i.idx);
          y_q <= y_q + (x_q >>> cmd_i.idx);
          z_q <= z_q - atan_v;
        end else begin
          x_q <= x_q + (y_q >>> cmd_i.idx);
          y_q <= y_q - (x_q >>> cmd_i.idx);
          z_q <= z_q + atan_v;
        end
      end
      ddo_pkg::OP_QUAT: begin
        qz_q <= clamp_unit(rnd_qz);
        qw_q <= clamp_unit(rnd_qw);
      end
      ddo_pkg::OP_LIN: lin_q <= sat32(rnd_lin);
      ddo_pkg::OP_ALO: acc_q <= p56;
      ddo_pkg::OP_AHI: acc_q <= acc_q + (p56 <<< 21);
      ddo_pkg::OP_OUT: begin
        out_data_o <= {5'b0, ang_v, lin_q, qw_q, qz_q, heading_q, pose_y_q, pose_x_q};
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/ddo_ctrl.sv]
// Odometry sequencer: steps the datapath through one word and drives the handshakes.
module ddo_ctrl #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ddo_pkg::dp_cmd_t cmd_o
);

  localparam int MAX_STEPS = (CORDIC_STEPS > ddo_pkg::WRAP_STEPS) ? CORDIC_STEPS
                                                                  : ddo_pkg::WRAP_STEPS;
  localparam int CNT_W = $clog2(MAX_STEPS);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL_DT, S_DT, S_WRAP_MID, S_WSTEP_MID, S_COR_MID, S_CSTEP_MID,
    S_MUL_DSC, S_POSX, S_MUL_DSS, S_POSY, S_WRAP_HEAD, S_WSTEP_HEAD, S_HEAD,
    S_COR_HALF, S_CSTEP_HALF, S_QUAT, S_MUL_LIN, S_LIN, S_MUL_ALO, S_ALO,
    S_MUL_AHI, S_AHI, S_OUT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             out_free;
  logic             wrap_last, cor_last;

  assign out_free    = !out_valid_q || out_ready_i;
  assign wrap_last   = (cnt_q == CNT_W'(ddo_pkg::WRAP_STEPS - 1));
  assign cor_last    = (cnt_q == CNT_W'(CORDIC_STEPS - 1));
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE:      if (in_valid_i) state_q <= S_MUL_DT;
        S_MUL_DT:    state_q <= S_DT;
        S_DT:        state_q <= S_WRAP_MID;
        S_WRAP_MID: begin
          cnt_q   <= '0;
          state_q <= S_WSTEP_MID;
        end
        S_WSTEP_MID: begin
          if (wrap_last) begin
            cnt_q   <= '0;
            state_q <= S_COR_MID;
          end else cnt_q <= cnt_q + 1'b1;
        end
        S_COR_MID:   state_q <= S_CSTEP_MID;
        S_CSTEP_MID: begin
          if (cor_last) begin
            cnt_q   <= '0;
            state_q <= S_MUL_DSC;
          end else cnt_q <= cnt_q + 1'b1;
        end
        S_MUL_DSC:   state_q <= S_POSX;
        S_POSX:      state_q <= S_MUL_DSS;
        S_MUL_DSS:   state_q <= S_POSY;
        S_POSY:      state_q <= S_WRAP_HEAD;
        S_WRAP_HEAD: begin
          cnt_q   <= '0;
          state_q <= S_WSTEP_HEAD;
        end
        S_WSTEP_HEAD: begin
          if (wrap_last) begin
            cnt_q   <= '0;
            state_q <= S_HEAD;
          end else cnt_q <= cnt_q + 1'b1;
        end
        S_HEAD:      state_q <= S_COR_HALF;
        S_COR_HALF:  state_q <= S_CSTEP_HALF;
        S_CSTEP_HALF: begin
          if (cor_last) begin
            cnt_q   <= '0;
            state_q <= S_QUAT;
          end else cnt_q <= cnt_q + 1'b1;
        end
        S_QUAT:      state_q <= S_MUL_LIN;
        S_MUL_LIN:   state_q <= S_LIN;
        S_LIN:       state_q <= S_MUL_ALO;
        S_MUL_ALO:   state_q <= S_ALO;
        S_ALO:       state_q <= S_MUL_AHI;
        S_MUL_AHI:   state_q <= S_AHI;
        S_AHI:       state_q <= S_OUT;
        S_OUT: begin
          // hold until the output register is free
          if (out_free) state_q <= S_IDLE;
        end
        default:     state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.op  = ddo_pkg::OP_NONE;
    cmd_o.idx = ddo_pkg::IDX_W'(cnt_q);
    unique case (state_q)
      S_IDLE:       cmd_o.op = in_valid_i ? ddo_pkg::OP_LOAD : ddo_pkg::OP_NONE;
      S_MUL_DT:     cmd_o.op = ddo_pkg::OP_MUL_DT;
      S_DT:         cmd_o.op = ddo_pkg::OP_DT;
      S_WRAP_MID:   cmd_o.op = ddo_pkg::OP_WRAP_MID;
      S_WSTEP_MID:  cmd_o.op = ddo_pkg::OP_WRAP_STEP;
      S_COR_MID:    cmd_o.op = ddo_pkg::OP_COR_MID;
      S_CSTEP_MID:  cmd_o.op = ddo_pkg::OP_COR_STEP;
      S_MUL_DSC:    cmd_o.op = ddo_pkg::OP_MUL_DSC;
      S_POSX:       cmd_o.op = ddo_pkg::OP_POSX;
      S_MUL_DSS:    cmd_o.op = ddo_pkg::OP_MUL_DSS;
      S_POSY:       cmd_o.op = ddo_pkg::OP_POSY;
      S_WRAP_HEAD:  cmd_o.op = ddo_pkg::OP_WRAP_HEAD;
      S_WSTEP_HEAD: cmd_o.op = ddo_pkg::OP_WRAP_STEP;
      S_HEAD:       cmd_o.op = ddo_pkg::OP_HEAD;
      S_COR_HALF:   cmd_o.op = ddo_pkg::OP_COR_HALF;
      S_CSTEP_HALF: cmd_o.op = ddo_pkg::OP_COR_STEP;
      S_QUAT:       cmd_o.op = ddo_pkg::OP_QUAT;
      S_MUL_LIN:    cmd_o.op = ddo_pkg::OP_MUL_LIN;
      S_LIN:        cmd_o.op = ddo_pkg::OP_LIN;
      S_MUL_ALO:    cmd_o.op = ddo_pkg::OP_MUL_ALO;
      S_ALO:        cmd_o.op = ddo_pkg::OP_ALO;
      S_MUL_AHI:    cmd_o.op = ddo_pkg::OP_MUL_AHI;
      S_AHI:        cmd_o.op = ddo_pkg::OP_AHI;
      S_OUT:        cmd_o.op = out_free ? ddo_pkg::OP_OUT : ddo_pkg::OP_NONE;
      default:      cmd_o.op = ddo_pkg::OP_NONE;
    endcase
  end

endmodule

[hw/rtl/diff_drive_odometry_top.sv]
// The two CORDIC passes and the two 14-step angle wraps all run on one shared iterative
// datapath, so a new word is taken only once the last one has left the datapath.
// A finished word waits in the output register while the next word is taken.
// Reset (asynchronous, active low) clears the pose and loads the register defaults.
module diff_drive_odometry_top #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // left_distance, right_distance
  input  logic [ddo_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // pos_x, pos_y, heading, quat_z, quat_w, linear_velocity, yaw_rate, pad
  output logic [ddo_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ddo_pkg::CFG_W-1:0]        cfg_data_i
);

  ddo_pkg::dp_cmd_t cmd;

  ddo_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd)
  );

  ddo_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_data_i (s_axis_tdata),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .out_data_o(m_axis_tdata)
  );

endmodule

[hw/rtl/ddo_checker.sv]
// Port-level checks for the odometry block, bound to the top level.
module ddo_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ddo_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic signed [30:0] heading;
  logic signed [17:0] quat_z, quat_w;

  assign heading = m_axis_tdata[94:64];
  assign quat_z  = m_axis_tdata[112:95];
  assign quat_w  = m_axis_tdata[130:113];

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // one word in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (heading <= 31'sd843314857) && (heading >= -31'sd843314857))
    else $error("heading outside wrap range");

  a_quat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (quat_z <= 18'sd65536) && (quat_z >= -18'sd65536) &&
                      (quat_w <= 18'sd65536) && (quat_w >= -18'sd65536))
    else $error("quaternion term out of range");

endmodule

bind diff_drive_odometry_top ddo_checker u_ddo_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

[verif/tb.sv]
// Self-checking testbench for the differential-drive odometry block.
module tb;

  typedef struct {
    logic [ddo_pkg::IN_DATA_W-1:0] data;
    bit                            drain;
  } wheel_item_t;

  typedef struct {
    logic [ddo_pkg::POS_W-1:0]  px;
    logic [ddo_pkg::POS_W-1:0]  py;
    logic [ddo_pkg::HEAD_W-1:0] hd;
    logic [ddo_pkg::QUAT_W-1:0] qz;
    logic [ddo_pkg::QUAT_W-1:0] qw;
    logic [ddo_pkg::VEL_W-1:0]  lv;
    logic [ddo_pkg::VEL_W-1:0]  av;
  } odo_word_t;

  localparam longint QUARTER_PI = 64'sd210828714;
  localparam int     SETTLE     = 2 * ddo_pkg::CORDIC_STEPS + 60;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [ddo_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [ddo_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           cfg_we_i = 1'b0;
  logic [ddo_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [ddo_pkg::CFG_W-1:0]      cfg_data_i = '0;

  wheel_item_t wheel_q[$];
  odo_word_t   pose_exp_q[$];
  int          err_cnt = 0;
  int          src_idle = 0;
  int          snk_stall = 0;
  bit          long_hold = 1'b0;
  bit          hold_req = 1'b0;

  // predictor state and registers
  longint inv_track, rate_hz;
  longint est_x, est_y, est_h;
  longint atan_tab[32];

  diff_drive_odometry_top uut (.*);

  always #1 clk_i = ~clk_i;

  function automatic longint round_half(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat_32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_q16(longint v);
    if (v > 65536) return 65536;
    if (v < -65536) return -65536;
    return v;
  endfunction

  function automatic longint wrap_pi(longint a);
    longint r;
    r = a % longint'(ddo_pkg::TWO_PI_Q28);
    if (r > longint'(ddo_pkg::PI_Q28)) r -= longint'(ddo_pkg::TWO_PI_Q28);
    if (r < -longint'(ddo_pkg::PI_Q28)) r += longint'(ddo_pkg::TWO_PI_Q28);
    return r;
  endfunction

  task automatic rotate(input longint a, output longint c, output longint s);
    longint x, y, z, nx, dx, dy;
    bit     neg;
    int     n;
    x = longint'(ddo_pkg::CORDIC_GAIN_Q30); y = 0; z = a; neg = 0;
    n = ddo_pkg::CORDIC_STEPS > 32 ? 32 : ddo_pkg::CORDIC_STEPS;
    if (z > longint'(ddo_pkg::HALF_PI_Q28)) begin
      z -= longint'(ddo_pkg::PI_Q28); neg = 1;
    end else if (z < -longint'(ddo_pkg::HALF_PI_Q28)) begin
      z += longint'(ddo_pkg::PI_Q28); neg = 1;
    end
    for (int i = 0; i < n; i++) begin
      dy = y >>> i; dx = x >>> i;
      if (z >= 0) begin
        nx = x - dy; y = y + dx; z -= atan_tab[i];
      end else begin
        nx = x + dy; y = y - dx; z += atan_tab[i];
      end
      x = nx;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endtask

  task automatic advance_pose(input logic [ddo_pkg::IN_DATA_W-1:0] d, output odo_word_t w);
    longint lft, rgt, dth, ds, mid, c, s, qz, qw, lv, av;
    lft = longint'($signed(d[23:0]));
    rgt = longint'($signed(d[47:24]));
    dth = round_half((rgt - lft) * inv_track, 8);
    ds  = lft + rgt;
    mid = wrap_pi(est_h + (dth >>> 1));
    rotate(mid, c, s);
    est_x = sat_32(est_x + round_half(ds * c, 35));
    est_y = sat_32(est_y + round_half(ds * s, 35));
    est_h = wrap_pi(est_h + dth);
    rotate(est_h >>> 1, c, s);
    qz = clamp_q16(round_half(s, 14));
    qw = clamp_q16(round_half(c, 14));
    lv = sat_32(round_half(ds * rate_hz, 5));
    av = sat_32(round_half(dth * rate_hz, 12));
    w.px = est_x[ddo_pkg::POS_W-1:0];
    w.py = est_y[ddo_pkg::POS_W-1:0];
    w.hd = est_h[ddo_pkg::HEAD_W-1:0];
    w.qz = qz[ddo_pkg::QUAT_W-1:0];
    w.qw = qw[ddo_pkg::QUAT_W-1:0];
    w.lv = lv[ddo_pkg::VEL_W-1:0];
    w.av = av[ddo_pkg::VEL_W-1:0];
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("tb: mismatch %s got %0h want %0h", what, got, want);
    err_cnt++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    odo_word_t   w;
    wheel_item_t it;
    bit          busy;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      busy = s_axis_tvalid && !s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        advance_pose(s_axis_tdata, w);
        pose_exp_q.push_back(w);
      end
      if (!busy) begin
        if (wheel_q.size() > 0 && wheel_q[0].drain && !s_axis_tvalid
            && pose_exp_q.size() == 0)
          void'(wheel_q.pop_front());
        if (wheel_q.size() > 0 && !wheel_q[0].drain
            && $urandom_range(99) >= src_idle) begin
          it = wheel_q.pop_front();
          s_axis_tdata  <= it.data;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    odo_word_t e, g;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        g.px = m_axis_tdata[31:0];
        g.py = m_axis_tdata[63:32];
        g.hd = m_axis_tdata[94:64];
        g.qz = m_axis_tdata[112:95];
        g.qw = m_axis_tdata[130:113];
        g.lv = m_axis_tdata[162:131];
        g.av = m_axis_tdata[194:163];
        if (pose_exp_q.size() == 0) begin
          report("unexpected word", 64'sd0, 64'sd0);
        end else begin
          e = pose_exp_q.pop_front();
          if (g.px !== e.px) report("pos_x", longint'(g.px), longint'(e.px));
          if (g.py !== e.py) report("pos_y", longint'(g.py), longint'(e.py));
          if (g.hd !== e.hd) report("heading", longint'(g.hd), longint'(e.hd));
          if (g.qz !== e.qz) report("quat_z", longint'(g.qz), longint'(e.qz));
          if (g.qw !== e.qw) report("quat_w", longint'(g.qw), longint'(e.qw));
          if (g.lv !== e.lv) report("linear_velocity", longint'(g.lv), longint'(e.lv));
          if (g.av !== e.av) report("yaw_rate", longint'(g.av), longint'(e.av));
        end
      end
      m_axis_tready <= !long_hold && ($urandom_range(99) >= snk_stall);
    end
  end

  // long receiver hold-off, counted here
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    long_hold = 1'b1;
    repeat (1500) @(posedge clk_i);
    long_hold = 1'b0;
  end

  initial begin
    #1000000;
    $display("tb: done, errors");
    $finish;
  end

  task automatic push_item(input longint l, input longint r);
    wheel_item_t it;
    it.data  = {r[23:0], l[23:0]};
    it.drain = 1'b0;
    wheel_q.push_back(it);
  endtask

  task automatic push_drain();
    wheel_item_t it;
    it.data  = '0;
    it.drain = 1'b1;
    wheel_q.push_back(it);
  endtask

  // sampled on the falling edge, where every driver update has settled
  task automatic wait_idle();
    while (wheel_q.size() > 0 || s_axis_tvalid || pose_exp_q.size() > 0)
      @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ddo_pkg::CFG_IDX_W-1:0] idx, input longint v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v[ddo_pkg::CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ddo_pkg::REG_INV_TRACK) inv_track = v & 64'hFFFFFF;
    else rate_hz = v & 64'hFFF;
    @(posedge clk_i);
  endtask

  task automatic push_random(input int n);
    longint l, r, b;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: begin
          l = longint'($signed(24'($urandom)));
          r = longint'($signed(24'($urandom)));
        end
        1: begin
          l = $urandom_range(1) ? 64'sd8388607 : -64'sd8388608;
          r = $urandom_range(1) ? 64'sd8388607 : -64'sd8388608;
        end
        2: begin
          l = longint'($signed(24'($urandom))); r = -l;
        end
        default: begin
          // typical motion: similar wheel travel, small differences
          b = longint'($signed(18'($urandom)));
          l = b + longint'($signed(12'($urandom)));
          r = b + longint'($signed(12'($urandom)));
        end
      endcase
      push_item(l, r);
    end
  endtask

  initial begin
    longint sum;
    bit     add;
    atan_tab[0] = QUARTER_PI;
    for (int i = 1; i < 32; i++) begin
      sum = 0; add = 1;
      for (int k = 1; i * k < 60; k += 2) begin
        sum = add ? sum + (64'sd1 <<< (60 - i * k)) / k
                  : sum - (64'sd1 <<< (60 - i * k)) / k;
        add = !add;
      end
      atan_tab[i] = (sum + (64'sd1 <<< 31)) >>> 32;
    end
    inv_track = longint'(ddo_pkg::INV_TRACK_RESET);
    rate_hz   = longint'(ddo_pkg::RATE_RESET);
    est_x = 0; est_y = 0; est_h = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset registers
    push_item(0, 0);
    push_item(8388607, 8388607);
    push_item(-8388608, -8388608);
    push_item(-8388608, 8388607);
    push_item(8388607, -8388608);
    push_item(-1, 1);
    push_item(1, -1);
    push_item(-1, -1);
    for (int k = 0; k < 6; k++) push_item(-3000000, 3000000); // heading wrap
    for (int k = 0; k < 6; k++) push_item(2500000, -2500000);
    push_item(1048576, 1048576);
    push_item(5592405, -5592406);
    push_item(-5592406, 5592405);
    push_item(12345, 54321);
    wait_idle();

    // extremes of the registers, large turns
    write_reg(ddo_pkg::REG_INV_TRACK, 64'hFFFFFF);
    write_reg(ddo_pkg::REG_UPDATE_RATE, 64'hFFF);
    src_idle = 62;
    push_item(-8388608, 8388607);
    push_item(8388607, -8388608);
    push_random(120);
    wait_idle();

    write_reg(ddo_pkg::REG_INV_TRACK, 64'sd1);
    write_reg(ddo_pkg::REG_UPDATE_RATE, 64'sd1);
    src_idle = 0; snk_stall = 62;
    push_random(120);
    wait_idle();

    // zero registers: no turn, no velocity
    write_reg(ddo_pkg::REG_INV_TRACK, 64'sd0);
    write_reg(ddo_pkg::REG_UPDATE_RATE, 64'sd0);
    src_idle = 11; snk_stall = 11;
    push_random(40);
    wait_idle();

    // receiver held off while items keep coming, then a drained pause
    write_reg(ddo_pkg::REG_INV_TRACK, longint'(ddo_pkg::INV_TRACK_RESET));
    write_reg(ddo_pkg::REG_UPDATE_RATE, longint'(ddo_pkg::RATE_RESET));
    src_idle = 0; snk_stall = 0;
    push_random(20);
    hold_req = 1'b1;
    push_drain();
    push_random(80);
    wait_idle();

    // random registers and idling phases
    for (int p = 0; p < 4; p++) begin
      write_reg(ddo_pkg::REG_INV_TRACK, longint'($urandom_range(24'hFFFFFF, 1)));
      write_reg(ddo_pkg::REG_UPDATE_RATE, longint'($urandom_range(12'hFFF, 1)));
      src_idle  = (p == 1 || p == 3) ? (p == 3 ? 11 : 62) : 0;
      snk_stall = (p == 2 || p == 3) ? (p == 3 ? 11 : 62) : 0;
      push_random(110);
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
